### src/olst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ordered list store.
// Used by the controller, the entry cells, the top level and the checker.
package olst_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int FUNC_W  = 4;
   localparam int INDEX_W = 5;
   localparam int VALUE_W = 32;
   localparam int DOUT_W  = 32;
   localparam int POS_W   = 5;
   localparam int LEN_W   = 5;
   localparam int STAT_W  = 2;
   // common width for position compares between the count and the index field
   localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   localparam logic [FUNC_W-1:0] FN_APPEND  = 4'd0;
   localparam logic [FUNC_W-1:0] FN_INSERT  = 4'd1;
   localparam logic [FUNC_W-1:0] FN_REPLACE = 4'd2;
   localparam logic [FUNC_W-1:0] FN_DELETE  = 4'd3;
   localparam logic [FUNC_W-1:0] FN_REMOVE  = 4'd4;
   localparam logic [FUNC_W-1:0] FN_GET     = 4'd5;
   localparam logic [FUNC_W-1:0] FN_POP     = 4'd6;
   localparam logic [FUNC_W-1:0] FN_FIND    = 4'd7;
   localparam logic [FUNC_W-1:0] FN_COUNT   = 4'd8;
   localparam logic [FUNC_W-1:0] FN_CLEAR   = 4'd9;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DOUT_W-1:0] data_out;
      logic [POS_W-1:0]  position;
      logic [LEN_W-1:0]  length;
      logic [STAT_W-1:0] status;
   } rsp_type;

   // per-cell update command, load wins over the shifts
   typedef struct packed {
      logic load;
      logic shift_up;
      logic shift_down;
   } cell_ctrl_type;

endpackage

### src/olst_cell.sv
`timescale 1ns / 1ps
// One entry cell of the ordered list: holds a word, takes a neighbor's word
// on a shift and registers its equality compare. Depends on olst_pkg.
module olst_cell (
   input  logic                             clock,
   input  olst_pkg::cell_ctrl_type          ctrl,
   input  logic [olst_pkg::DATA_WIDTH-1:0]  lower_entry,
   input  logic [olst_pkg::DATA_WIDTH-1:0]  upper_entry,
   input  logic [olst_pkg::DATA_WIDTH-1:0]  new_value,
   output logic [olst_pkg::DATA_WIDTH-1:0]  entry,
   output logic                             match
);
   import olst_pkg::*;

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  match_ff, match_in;

   always_comb begin
      priority if (ctrl.load) begin
         entry_in = new_value;
      end else if (ctrl.shift_up) begin
         entry_in = lower_entry;
      end else if (ctrl.shift_down) begin
         entry_in = upper_entry;
      end else begin
         entry_in = entry_ff;
      end
      match_in = (entry_ff == new_value);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

### src/olst_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer for the ordered list: holds the request and the length,
// decodes the operation into cell commands and builds the result beat.
// Depends on olst_pkg.
module olst_ctrl (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_valid,
   output logic                                              req_stall,
   input  olst_pkg::req_type                                 req_payload,
   output logic                                              rsp_valid,
   input  logic                                              rsp_stall,
   output olst_pkg::rsp_type                                 rsp_payload,
   input  logic [olst_pkg::CAPACITY-1:0][olst_pkg::DATA_WIDTH-1:0] cell_entry,
   input  logic [olst_pkg::CAPACITY-1:0]                     cell_match,
   output olst_pkg::cell_ctrl_type [olst_pkg::CAPACITY-1:0]  cell_ctrl,
   output logic [olst_pkg::DATA_WIDTH-1:0]                   new_value
);
   import olst_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MATCH = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept, fire, full;
   logic [CMP_W-1:0] cnt_x, idx_x, read_at, load_at, shift_at, first_at;
   logic             first_hit;
   logic [CNT_W-1:0] hit_num, new_cnt;
   logic [CAPACITY-1:0] hits;
   logic [DATA_WIDTH-1:0] read_data;
   logic             op_load, op_up, op_down;
   logic [DOUT_W-1:0] data_res;
   logic [POS_W-1:0] pos_res;
   logic [STAT_W-1:0] st_res;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   // execute once the output register is free or being drained
   assign fire      = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign new_value = DATA_WIDTH'(req_ff.value);

   assign cnt_x = CMP_W'(count_ff);
   assign idx_x = CMP_W'(req_ff.index);
   assign full  = (count_ff == CNT_W'(CAPACITY));

   // match bits count only inside the valid part of the list
   always_comb begin
      first_hit = 1'b0;
      first_at  = '0;
      hit_num   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hits[i] = cell_match[i] && (CMP_W'(i) < cnt_x);
         hit_num = hit_num + CNT_W'(hits[i]);
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hits[i]) begin
            first_hit = 1'b1;
            first_at  = CMP_W'(i);
         end
      end
   end

   assign read_at   = (req_ff.func == FN_POP) ? (cnt_x - CMP_W'(1)) : idx_x;
   assign read_data = cell_entry[IDX_W'(read_at)];

   always_comb begin
      op_load  = 1'b0;
      op_up    = 1'b0;
      op_down  = 1'b0;
      load_at  = cnt_x;
      shift_at = idx_x;
      new_cnt  = count_ff;
      data_res = '0;
      pos_res  = '0;
      st_res   = ST_OK;
      unique case (req_ff.func)
         FN_APPEND: begin
            if (full) begin
               st_res = ST_FULL;
            end else begin
               op_load = 1'b1;
               new_cnt = count_ff + CNT_W'(1);
            end
         end
         FN_INSERT: begin
            if (idx_x > cnt_x) begin
               st_res = ST_RANGE;
            end else if (full) begin
               st_res = ST_FULL;
            end else begin
               op_load = 1'b1;
               op_up   = 1'b1;
               load_at = idx_x;
               new_cnt = count_ff + CNT_W'(1);
            end
         end
         FN_REPLACE: begin
            if (idx_x > cnt_x) begin
               st_res = ST_RANGE;
            end else if (idx_x == cnt_x) begin
               if (full) begin
                  st_res = ST_FULL;
               end else begin
                  op_load = 1'b1;
                  new_cnt = count_ff + CNT_W'(1);
               end
            end else begin
               op_load  = 1'b1;
               load_at  = idx_x;
               data_res = DOUT_W'(read_data);
            end
         end
         FN_DELETE: begin
            if (idx_x >= cnt_x) begin
               st_res = ST_RANGE;
            end else begin
               op_down = 1'b1;
               new_cnt = count_ff - CNT_W'(1);
            end
         end
         FN_REMOVE: begin
            if (first_hit) begin
               op_down  = 1'b1;
               shift_at = first_at;
               new_cnt  = count_ff - CNT_W'(1);
               pos_res  = POS_W'(first_at);
            end else begin
               st_res = ST_MISS;
            end
         end
         FN_GET: begin
            if (idx_x >= cnt_x) begin
               st_res = ST_RANGE;
            end else begin
               data_res = DOUT_W'(read_data);
            end
         end
         FN_POP: begin
            if (count_ff == '0) begin
               st_res = ST_MISS;
            end else begin
               new_cnt  = count_ff - CNT_W'(1);
               data_res = DOUT_W'(read_data);
            end
         end
         FN_FIND: begin
            if (first_hit) begin
               pos_res = POS_W'(first_at);
            end else begin
               st_res = ST_MISS;
            end
         end
         FN_COUNT: begin
            pos_res = POS_W'(hit_num);
         end
         FN_CLEAR: begin
            new_cnt = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ctrl[i].load       = fire && op_load && (CMP_W'(i) == load_at);
         cell_ctrl[i].shift_up   = fire && op_up && (CMP_W'(i) > shift_at);
         cell_ctrl[i].shift_down = fire && op_down && (CMP_W'(i) >= shift_at);
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_payload;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (fire) begin
               count_in        = new_cnt;
               rsp_in.data_out = data_res;
               rsp_in.position = pos_res;
               rsp_in.length   = LEN_W'(new_cnt);
               rsp_in.status   = st_res;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### src/ordered_list_store_top.sv
`timescale 1ns / 1ps
// Ordered list store: fixed-capacity ordered word list with insert, delete,
// search and count. Top level; depends on olst_pkg, olst_ctrl, olst_cell.
//
// Usage:
//   Requests enter on req_valid / req_stall with a req_payload beat holding
//   func, index and value. Every request yields exactly one rsp_payload beat
//   (data_out, position, length, status) on rsp_valid / rsp_stall.
//   Entries live in a row of cells, one word each; insert and delete move all
//   later words one cell together, and every cell compares its word
//   with the request value in parallel.
//   The result is registered in two steps after the request beat is taken:
//   the cell compares are registered, then the request executes.
//   The controller takes no new request until the compare-then-execute
//   sequence is through; req_stall is high while a request is in work.
//   A finished result waits in the output register while the next request
//   is taken; if the receiver stalls, the execute step holds until the output
//   register drains, and the list is not changed before then.
//   Reset empties the list (length zero) and drops any pending result; word
//   storage itself is not cleared.
module ordered_list_store_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  olst_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output olst_pkg::rsp_type rsp_payload
);
   import olst_pkg::*;

   logic [CAPACITY-1:0][DATA_WIDTH-1:0] cell_entry;
   logic [CAPACITY-1:0]                 cell_match;
   cell_ctrl_type [CAPACITY-1:0]        cell_ctrl;
   logic [DATA_WIDTH-1:0]               new_value;

   olst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cell_entry  (cell_entry),
      .cell_match  (cell_match),
      .cell_ctrl   (cell_ctrl),
      .new_value   (new_value)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_entry, upper_entry;

      // end cells see their own word where there is no neighbor
      if (i == 0) begin : g_first
         assign lower_entry = cell_entry[i];
      end else begin : g_lower
         assign lower_entry = cell_entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper_entry = cell_entry[i];
      end else begin : g_upper
         assign upper_entry = cell_entry[i+1];
      end

      olst_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .lower_entry (lower_entry),
         .upper_entry (upper_entry),
         .new_value   (new_value),
         .entry       (cell_entry[i]),
         .match       (cell_match[i])
      );
   end

endmodule

### src/olst_check.sv
`timescale 1ns / 1ps
// Port-level checker for the ordered list store, bound to the top level.
// Depends on olst_pkg.
module olst_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input olst_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input olst_pkg::rsp_type rsp_payload
);
   import olst_pkg::*;

   a_reset_drops_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in work");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_FULL)
         |-> (rsp_payload.length == LEN_W'(CAPACITY)))
      else $error("full status with list not at capacity");

endmodule

bind ordered_list_store_top olst_check u_olst_check (.*);

### bench/ordered_list_store_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ordered_list_store_top: directed table, then random
// operation mixes checked against a shadow list. Depends on olst_pkg and the RTL.
module ordered_list_store_top_tb;
   import olst_pkg::*;

   localparam int RANDOM_ITEMS  = 600;
   localparam int EPISODE_ITEMS = 40;
   localparam int HOLD_CYCLES   = 80;
   localparam int HOLD_AFTER    = 150;
   localparam int STALL_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 8;

   localparam logic [FUNC_W-1:0]  FN_UNUSED = 4'd15;
   localparam logic [VALUE_W-1:0] ALL_ONES  = '1;

   typedef enum int { MIX_GROW, MIX_SHRINK, MIX_CHURN } mix_mode_type;

   typedef struct {
      req_type req;
      int      reps;
      bit      typed;
      rsp_type rsp;
   } probe_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // shadow copy of the list contents
   logic [DATA_WIDTH-1:0] shadow_words [CAPACITY];
   int                    shadow_len = 0;

   rsp_type       pending_results [$];
   probe_row_type probe_table [$];
   logic [VALUE_W-1:0] value_pool [4];
   int fail_count = 0;

   ordered_list_store_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type apply_list_op(input req_type r);
      rsp_type               res;
      logic [DATA_WIDTH-1:0] v;
      int                    at;
      int                    hits;
      int                    idx;
      res  = '0;
      v    = r.value[DATA_WIDTH-1:0];
      idx  = r.index;
      at   = -1;
      hits = 0;
      for (int i = 0; i < shadow_len; i++) begin
         if (shadow_words[i] == v) begin
            if (at < 0) at = i;
            hits++;
         end
      end
      case (r.func)
         FN_APPEND: begin
            if (shadow_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               shadow_words[shadow_len] = v;
               shadow_len++;
            end
         end
         FN_INSERT: begin
            if (idx > shadow_len) begin
               res.status = ST_RANGE;
            end else if (shadow_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int i = shadow_len; i > idx; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[idx] = v;
               shadow_len++;
            end
         end
         FN_REPLACE: begin
            if (idx > shadow_len) begin
               res.status = ST_RANGE;
            end else if (idx == shadow_len) begin
               // replace at the end behaves as append
               if (shadow_len >= CAPACITY) begin
                  res.status = ST_FULL;
               end else begin
                  shadow_words[shadow_len] = v;
                  shadow_len++;
               end
            end else begin
               res.data_out = DOUT_W'(shadow_words[idx]);
               shadow_words[idx] = v;
            end
         end
         FN_DELETE: begin
            if (idx >= shadow_len) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = idx; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
               shadow_len--;
            end
         end
         FN_REMOVE: begin
            if (at < 0) begin
               res.status = ST_MISS;
            end else begin
               for (int i = at; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
               shadow_len--;
               res.position = POS_W'(at);
            end
         end
         FN_GET: begin
            if (idx >= shadow_len) res.status = ST_RANGE;
            else res.data_out = DOUT_W'(shadow_words[idx]);
         end
         FN_POP: begin
            if (shadow_len == 0) begin
               res.status = ST_MISS;
            end else begin
               shadow_len--;
               res.data_out = DOUT_W'(shadow_words[shadow_len]);
            end
         end
         FN_FIND: begin
            if (at < 0) res.status = ST_MISS;
            else res.position = POS_W'(at);
         end
         FN_COUNT: res.position = POS_W'(hits);
         FN_CLEAR: shadow_len = 0;
         default: ;
      endcase
      res.length = LEN_W'(shadow_len);
      return res;
   endfunction

   function automatic void add_row(input logic [FUNC_W-1:0] f, input int idx,
                                   input logic [VALUE_W-1:0] val, input int reps,
                                   input bit typed, input logic [DOUT_W-1:0] d,
                                   input int p, input int l, input logic [STAT_W-1:0] s);
      probe_row_type row;
      row.req.func      = f;
      row.req.index     = INDEX_W'(idx);
      row.req.value     = val;
      row.reps          = reps;
      row.typed         = typed;
      row.rsp.data_out  = d;
      row.rsp.position  = POS_W'(p);
      row.rsp.length    = LEN_W'(l);
      row.rsp.status    = s;
      probe_table.push_back(row);
   endfunction

   // mostly no pause, sometimes a few cycles, now and then a long one
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func(input mix_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return FUNC_W'($urandom_range(FN_CLEAR + 1, (1 << FUNC_W) - 1));
      if (r < 3) return FN_CLEAR;
      r = $urandom_range(0, 99);
      case (mode)
         MIX_GROW: begin
            if (r < 40) return FN_APPEND;
            if (r < 60) return FN_INSERT;
            if (r < 70) return FN_REPLACE;
         end
         MIX_SHRINK: begin
            if (r < 25) return FN_DELETE;
            if (r < 45) return FN_REMOVE;
            if (r < 65) return FN_POP;
         end
         default: begin
            if (r < 15) return FN_APPEND;
            if (r < 25) return FN_INSERT;
            if (r < 35) return FN_REPLACE;
            if (r < 45) return FN_DELETE;
            if (r < 55) return FN_REMOVE;
            if (r < 62) return FN_POP;
         end
      endcase
      case ($urandom_range(0, 2))
         0:       return FN_GET;
         1:       return FN_FIND;
         default: return FN_COUNT;
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return INDEX_W'($urandom_range(0, shadow_len));
      if (r < 95) return INDEX_W'($urandom_range(0, CAPACITY));
      return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return value_pool[$urandom_range(0, 3)];
      if (r < 75) return '0;
      if (r < 80) return ALL_ONES;
      return VALUE_W'($urandom);
   endfunction

   function automatic void report_field(input string what, input logic [DOUT_W-1:0] want,
                                        input logic [DOUT_W-1:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
   endfunction

   function automatic void check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_field("unexpected result", '0, DOUT_W'(got));
         return;
      end
      want = pending_results.pop_front();
      if (got.data_out !== want.data_out) report_field("data_out", want.data_out, got.data_out);
      if (got.position !== want.position) report_field("position", want.position, got.position);
      if (got.length !== want.length) report_field("length", want.length, got.length);
      if (got.status !== want.status) report_field("status", want.status, got.status);
   endfunction

   // offer one beat; record its expectation once it is taken
   task automatic offer_request(input req_type r, input int gap, input bit typed,
                                input rsp_type known);
      rsp_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_list_op(r);
      pending_results.push_back(typed ? known : predicted);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin : request_source
      req_type      r;
      mix_mode_type mode;
      bit           burst;
      int           sent;
      // error paths and an empty count on the empty list
      add_row(FN_GET, 0, 0, 1, 1, 0, 0, 0, ST_RANGE);
      add_row(FN_POP, 0, 0, 1, 1, 0, 0, 0, ST_MISS);
      add_row(FN_DELETE, 0, 0, 1, 1, 0, 0, 0, ST_RANGE);
      add_row(FN_FIND, 0, 0, 1, 1, 0, 0, 0, ST_MISS);
      add_row(FN_REMOVE, 0, ALL_ONES, 1, 1, 0, 0, 0, ST_MISS);
      add_row(FN_COUNT, 0, 0, 1, 1, 0, 0, 0, ST_OK);
      add_row(FN_INSERT, 1, 5, 1, 1, 0, 0, 0, ST_RANGE);
      add_row(FN_REPLACE, 1, 5, 1, 1, 0, 0, 0, ST_RANGE);
      // replace at the end appends
      add_row(FN_REPLACE, 0, ALL_ONES, 1, 1, 0, 0, 1, ST_OK);
      add_row(FN_APPEND, 0, 0, 1, 1, 0, 0, 2, ST_OK);
      add_row(FN_INSERT, 0, 32'h1234_5678, 1, 1, 0, 0, 3, ST_OK);
      add_row(FN_INSERT, 3, 32'h8000_0001, 1, 1, 0, 0, 4, ST_OK);
      add_row(FN_GET, 1, 0, 1, 0, 0, 0, 0, ST_OK);
      add_row(FN_REPLACE, 2, 32'hA5A5_A5A5, 1, 0, 0, 0, 0, ST_OK);
      add_row(FN_FIND, 0, ALL_ONES, 1, 0, 0, 0, 0, ST_OK);
      add_row(FN_REMOVE, 0, 32'h1234_5678, 1, 0, 0, 0, 0, ST_OK);
      add_row(FN_DELETE, 1, 0, 1, 0, 0, 0, 0, ST_OK);
      add_row(FN_COUNT, 0, 0, 1, 0, 0, 0, 0, ST_OK);
      add_row(FN_UNUSED, 31, ALL_ONES, 1, 0, 0, 0, 0, ST_OK);
      add_row(FN_CLEAR, 0, 0, 1, 1, 0, 0, 0, ST_OK);
      // fill to capacity, then full-list corners
      add_row(FN_APPEND, 0, 32'h5A5A_5A5A, CAPACITY, 0, 0, 0, 0, ST_OK);
      add_row(FN_APPEND, 0, 1, 1, 1, 0, 0, 16, ST_FULL);
      add_row(FN_INSERT, 3, 1, 1, 1, 0, 0, 16, ST_FULL);
      add_row(FN_INSERT, 17, 1, 1, 1, 0, 0, 16, ST_RANGE);
      add_row(FN_REPLACE, 16, 1, 1, 1, 0, 0, 16, ST_FULL);
      add_row(FN_REPLACE, 31, 1, 1, 1, 0, 0, 16, ST_RANGE);
      add_row(FN_COUNT, 0, 32'h5A5A_5A5A, 1, 1, 0, 16, 16, ST_OK);
      add_row(FN_GET, 15, 0, 1, 1, 32'h5A5A_5A5A, 0, 16, ST_OK);
      add_row(FN_GET, 16, 0, 1, 1, 0, 0, 16, ST_RANGE);
      add_row(FN_DELETE, 16, 0, 1, 1, 0, 0, 16, ST_RANGE);
      add_row(FN_POP, 0, 0, 1, 1, 32'h5A5A_5A5A, 0, 15, ST_OK);
      add_row(FN_CLEAR, 0, 0, 1, 1, 0, 0, 0, ST_OK);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_table[i])
         repeat (probe_table[i].reps)
            offer_request(probe_table[i].req, pick_pause(), probe_table[i].typed,
                          probe_table[i].rsp);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode  = mix_mode_type'($urandom_range(0, 2));
         burst = ($urandom_range(0, 3) == 0);
         foreach (value_pool[i])
            value_pool[i] = ($urandom_range(0, 3) == 0) ?
                            (($urandom_range(0, 1) == 0) ? '0 : ALL_ONES) : VALUE_W'($urandom);
         for (int k = 0; k < EPISODE_ITEMS && sent < RANDOM_ITEMS; k++) begin
            // hold off once mid-run until every result is back
            if (sent == RANDOM_ITEMS / 2) wait_for_drain();
            r.func  = pick_func(mode);
            r.index = pick_index();
            r.value = pick_value();
            offer_request(r, burst ? 0 : pick_pause(), 1'b0, '0);
            sent++;
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ordered_list_store_top test passed");
      end else begin
         $display("ordered_list_store_top test failed");
      end
      $finish;
   end

   initial begin : result_sink
      int stall_left;
      int stretch_left;
      int results_seen;
      bit quiet;
      bit hold_done;
      stall_left   = 0;
      stretch_left = 0;
      results_seen = 0;
      quiet        = 1'b0;
      hold_done    = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_payload);
            results_seen++;
         end
         if (stretch_left == 0) begin
            quiet        = ($urandom_range(0, 3) == 0);
            stretch_left = 64;
         end
         stretch_left--;
         // one long hold so the block backs up into its input
         if (!hold_done && results_seen == HOLD_AFTER) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = pick_pause();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("ordered_list_store_top test failed");
      $finish;
   end

endmodule

### ordered_list_store_top.f
src/olst_pkg.sv
src/olst_cell.sv
src/olst_ctrl.sv
src/ordered_list_store_top.sv
src/olst_check.sv
bench/ordered_list_store_top_tb.sv
